FILE: rtl/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

    localparam int unsigned CODE_MAX     = 255;
    localparam int unsigned CAP_RESET    = 65535;
    localparam int unsigned FIFO_DEPTH   = 4;
    localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned S_TDATA_W    = 24;
    localparam int unsigned M_TDATA_W    = 32;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_SRC_LEN      = 2'd1,
        ST_INVALID_ZERO = 2'd2,
        ST_DEST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_status;
        status_t     status;
        logic [15:0] out_length;
        logic        last;
    } dec_out_t;

    // results made by one item, n is 0, 1 or 2
    typedef struct packed {
        logic [1:0] n;
        dec_out_t   r0;
        dec_out_t   r1;
    } push_t;

endpackage

`default_nettype wire

FILE: rtl/cobs_frame_decoder.sv
// channel  dir  handshake                 payload
// s_       in   s_tvalid / s_tready       s_tdata: data_byte, frame_length
// m_       out  m_tvalid / m_tready       m_tdata, m_tuser, m_tlast
// cfg_     in   cfg_valid / cfg_ready     cfg_data: dest_capacity
//
// one input item per cycle: an input register feeds the decode logic, whose
// zero, one or two results go into a four-entry output queue
// the input side stalls only while that queue has fewer than two free entries
// an item carrying two results adds one more result for the queue to drain
// reset returns to the start of a frame and dest_capacity to 65535
`default_nettype none

module cobs_frame_decoder
    import cfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // data_byte[7:0], frame_length[23:8]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // out_byte[7:0], status[9:8], out_length[25:10]
    output logic                      m_tuser,   // is_status
    output logic                      m_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [15:0]          cfg_data
);

    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic                 fire;
    logic                 room2;
    push_t                push;
    dec_out_t             head;

    assign fire      = in_valid_reg && room2;
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    cfd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_value    (cfg_data),
        .fire         (fire),
        .data_byte    (in_data_reg[7:0]),
        .frame_length (in_data_reg[23:8]),
        .push         (push)
    );

    cfd_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fire),
        .push     (push),
        .room2    (room2),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (head)
    );

    assign m_tdata = {6'd0, head.out_length, head.status, head.out_byte};
    assign m_tuser = head.is_status;
    assign m_tlast = head.last;

endmodule

`default_nettype wire

FILE: rtl/cfd_core.sv
`default_nettype none

module cfd_core
    import cfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_value,
    input  wire logic        fire,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] frame_length,
    output push_t            push
);

    logic [15:0] cap_reg;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] cnt_reg, cnt_next;
    status_t     err_reg, err_next;

    logic [16:0] len17;
    logic [16:0] pos17;
    logic        is_final;
    logic        blk_over;
    logic        zero_room;
    logic        done;
    logic [7:0]  code_eff;
    logic [15:0] cnt_mid;
    logic        byte_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= 16'(CAP_RESET);
            pos_reg  <= '0;
            rem_reg  <= '0;
            code_reg <= '0;
            cnt_reg  <= '0;
            err_reg  <= ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_value;
            end
            if (fire)
            begin
                pos_reg  <= pos_next;
                rem_reg  <= rem_next;
                code_reg <= code_next;
                cnt_reg  <= cnt_next;
                err_reg  <= err_next;
            end
        end
    end

    always_comb
    begin
        len17     = {1'b0, frame_length};
        pos17     = {1'b0, pos_reg};
        is_final  = (frame_length == 16'd0) || (pos17 >= len17 - 17'd1);
        blk_over  = (pos17 + {9'd0, data_byte}) >= len17;
        zero_room = (pos17 + 17'd2) < len17;

        pos_next  = pos_reg + 16'd1;
        rem_next  = rem_reg;
        code_next = code_reg;
        cnt_next  = cnt_reg;
        err_next  = err_reg;
        done      = 1'b0;
        code_eff  = code_reg;
        cnt_mid   = cnt_reg;
        byte_out  = 1'b0;

        push      = '0;

        if (is_final)
        begin
            push.n               = 2'd1;
            push.r0.is_status    = 1'b1;
            push.r0.last         = 1'b1;
            if ((frame_length == 16'd0) || (data_byte != 8'd0))
            begin
                push.r0.status = ST_SRC_LEN;
            end
            else if (err_reg != ST_OK)
            begin
                push.r0.status = err_reg;
            end
            else if (rem_reg != 8'd0)
            begin
                push.r0.status = ST_SRC_LEN;
            end
            else
            begin
                push.r0.status     = ST_OK;
                push.r0.out_length = cnt_reg;
            end
            pos_next  = '0;
            rem_next  = '0;
            code_next = '0;
            cnt_next  = '0;
            err_next  = ST_OK;
        end
        else if (err_reg == ST_OK)
        begin
            if (rem_reg == 8'd0)
            begin
                // code byte opens a block
                if (data_byte == 8'd0)
                begin
                    err_next = ST_INVALID_ZERO;
                end
                else if (blk_over)
                begin
                    err_next = ST_SRC_LEN;
                end
                else
                begin
                    code_next = data_byte;
                    code_eff  = data_byte;
                    rem_next  = data_byte - 8'd1;
                    done      = (data_byte == 8'd1);
                end
            end
            else
            begin
                if (cnt_reg >= cap_reg)
                begin
                    err_next = ST_DEST_FULL;
                end
                else if (data_byte == 8'd0)
                begin
                    err_next = ST_INVALID_ZERO;
                end
                else
                begin
                    byte_out          = 1'b1;
                    push.n            = 2'd1;
                    push.r0.out_byte  = data_byte;
                    push.r0.last      = 1'b1;
                    cnt_mid           = cnt_reg + 16'd1;
                    rem_next          = rem_reg - 8'd1;
                    done              = (rem_reg == 8'd1);
                end
            end

            cnt_next = cnt_mid;
            // implied zero after a short block, not before the terminator
            if (done && (code_eff < 8'(CODE_MAX)) && zero_room)
            begin
                if (cnt_mid >= cap_reg)
                begin
                    err_next = ST_DEST_FULL;
                end
                else
                begin
                    cnt_next = cnt_mid + 16'd1;
                    if (byte_out)
                    begin
                        push.n       = 2'd2;
                        push.r0.last = 1'b0;
                        push.r1.last = 1'b1;
                    end
                    else
                    begin
                        push.n       = 2'd1;
                        push.r0.last = 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cfd_out_fifo.sv
`default_nettype none

module cfd_out_fifo
    import cfd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire push_t push,
    output logic       room2,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output dec_out_t   rd_data
);

    dec_out_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FIFO_CNT_W-1:0]  n_push;
    logic                   pop;
    logic [FIFO_PTR_W-1:0]  wr_ptr_p1;

    always_comb
    begin
        rd_valid    = (cnt_reg != '0);
        n_push      = wr_en ? FIFO_CNT_W'(push.n) : '0;
        pop         = rd_valid && rd_ready;
        wr_ptr_p1   = wr_ptr_reg + FIFO_PTR_W'(1);
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        cnt_next    = cnt_reg + n_push - FIFO_CNT_W'(pop);
        rd_data     = mem_reg[rd_ptr_reg];
        room2       = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != '0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (n_push == FIFO_CNT_W'(2))
        begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cfd_checker.sv
`default_nettype none

module cfd_checker
    import cfd_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tuser,
    input wire logic                 m_tlast
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // end-of-frame status always closes the run of its item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("status item without tlast");

    // byte items carry no status and no length
    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[25:8] == 18'd0))
        else $error("byte item with status or length");

    // failed frames report zero length
    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && (m_tdata[9:8] != ST_OK) |-> (m_tdata[25:10] == 16'd0))
        else $error("error status with nonzero length");

endmodule

bind cobs_frame_decoder cfd_checker u_chk (.*);

`default_nettype wire

FILE: verif/tb.sv
module tb;
    import cfd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int TARGET_ITEMS  = 1850;
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_MAX    = 10;

    typedef enum int {
        BREAK_TERMINATOR,
        BREAK_ZERO_BYTE,
        BREAK_RANDOM_BYTE,
        BREAK_LENGTH,
        BREAK_TRUNCATE
    } break_kind_t;

    class cobs_checker;
        dec_out_t    pending_results[$];
        logic [15:0] capacity;
        logic [15:0] position;
        logic [7:0]  remaining;
        logic [7:0]  code;
        logic [15:0] decoded;
        status_t     err;
        int          mismatches;
        int          results_checked;
        int          status_count[4];

        function new();
            capacity = 16'hFFFF;
            mismatches = 0;
            results_checked = 0;
            foreach (status_count[i])
                status_count[i] = 0;
            restart();
        endfunction

        function void restart();
            position = '0;
            remaining = '0;
            code = '0;
            decoded = '0;
            err = ST_OK;
        endfunction

        function void set_capacity(logic [15:0] v);
            capacity = v;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // expected results of one accepted encoded byte
        function void decode_byte(logic [7:0] b, logic [15:0] len);
            int unsigned p;
            int unsigned l;
            int unsigned blen;
            dec_out_t    r [2];
            int          n;
            bit          done;
            status_t     st;
            logic [15:0] olen;
            p = position;
            l = len;
            n = 0;
            done = 1'b0;
            r[0] = '0;
            r[1] = '0;
            if (l == 0 || p >= l - 1)
            begin
                olen = '0;
                if (l == 0 || b != 8'h00)
                    st = ST_SRC_LEN;
                else if (err != ST_OK)
                    st = err;
                else if (remaining != 8'h00)
                    st = ST_SRC_LEN;
                else
                begin
                    st = ST_OK;
                    olen = decoded;
                end
                r[0].is_status = 1'b1;
                r[0].status = st;
                r[0].out_length = olen;
                r[0].last = 1'b1;
                pending_results.push_back(r[0]);
                status_count[st]++;
                restart();
                return;
            end
            position = 16'(p + 1);
            if (err != ST_OK)
                return;
            if (remaining == 8'h00)
            begin
                if (b == 8'h00)
                begin
                    err = ST_INVALID_ZERO;
                    return;
                end
                blen = int'(b) - 1;
                // block would reach the terminator
                if (p + 1 + blen >= l)
                begin
                    err = ST_SRC_LEN;
                    return;
                end
                code = b;
                remaining = 8'(blen);
                done = (blen == 0);
            end
            else
            begin
                // capacity check wins over the zero check
                if (decoded >= capacity)
                begin
                    err = ST_DEST_FULL;
                    return;
                end
                if (b == 8'h00)
                begin
                    err = ST_INVALID_ZERO;
                    return;
                end
                r[n].out_byte = b;
                n++;
                decoded++;
                remaining--;
                done = (remaining == 8'h00);
            end
            if (done && code < CODE_MAX && p + 1 < l - 1)
            begin
                if (decoded >= capacity)
                    err = ST_DEST_FULL;
                else
                begin
                    r[n].out_byte = 8'h00;
                    n++;
                    decoded++;
                end
            end
            for (int i = 0; i < n; i++)
            begin
                if (i == n - 1)
                    r[i].last = 1'b1;
                pending_results.push_back(r[i]);
            end
        endfunction

        function void check_result(dec_out_t act);
            dec_out_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: byte %h is_status %b status %0d length %0d last %b",
                             act.out_byte, act.is_status, act.status, act.out_length, act.last);
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (act.out_byte !== want.out_byte || act.is_status !== want.is_status ||
                act.status !== want.status || act.out_length !== want.out_length ||
                act.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("mismatch: expected byte %h is_status %b status %0d length %0d last %b",
                             want.out_byte, want.is_status, want.status, want.out_length,
                             want.last);
                    $display("          got      byte %h is_status %b status %0d length %0d last %b",
                             act.out_byte, act.is_status, act.status, act.out_length, act.last);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // data_byte[7:0], frame_length[23:8]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // out_byte[7:0], status[9:8], out_length[25:10]
    logic                 m_tuser;        // is_status
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [15:0]          cfg_data = '0;

    cobs_checker sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int pause_at = -1;
    int cycles = 0;
    int cap_writes = 0;

    cobs_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("tb: errors");
        $finish;
    end

    // result side: sample before the edge updates, then pick the next ready
    initial
    begin
        dec_out_t act;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                act.out_byte = m_tdata[7:0];
                act.status = status_t'(m_tdata[9:8]);
                act.out_length = m_tdata[25:10];
                act.is_status = m_tuser;
                act.last = m_tlast;
                sb.check_result(act);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(input logic [7:0] b, input logic [15:0] len);
        if (items_sent == pause_at)
            wait_drained();
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {len, b};
        do
            @(posedge clk);
        while (!s_tready);
        sb.decode_byte(b, len);
        items_sent++;
    endtask

    task automatic write_capacity(input logic [15:0] v);
        wait_drained();
        // a dropped byte may still sit in the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(v);
        cap_writes++;
    endtask

    // bytes given first-in-highest
    task automatic send_packed(input logic [63:0] seq, input int n, input logic [15:0] len);
        for (int i = 0; i < n; i++)
            send_item(seq[8*(n-1-i) +: 8], len);
    endtask

    function automatic logic [15:0] pick_capacity();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'h0000;
        else if (r == 1)
            return 16'hFFFF;
        else if (r < 7)
            return 16'($urandom_range(1, 24));
        return 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic void build_frame(input int n, input int zero_pct,
                                        output logic [7:0] enc[$]);
        int code_idx;
        int run;
        logic [7:0] b;
        enc = {};
        enc.push_back(8'h00);
        code_idx = 0;
        run = 1;
        for (int i = 0; i < n; i++)
        begin
            b = ($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
            if (b == 8'h00)
            begin
                enc[code_idx] = 8'(run);
                code_idx = enc.size();
                enc.push_back(8'h00);
                run = 1;
            end
            else
            begin
                enc.push_back(b);
                run++;
                if (run == CODE_MAX)
                begin
                    enc[code_idx] = 8'(CODE_MAX);
                    code_idx = enc.size();
                    enc.push_back(8'h00);
                    run = 1;
                end
            end
        end
        enc[code_idx] = 8'(run);
        enc.push_back(8'h00);
    endfunction

    function automatic int pick_payload_size();
        if ($urandom_range(99) < 2)
            return $urandom_range(250, 300);
        return $urandom_range(0, 12);
    endfunction

    task automatic send_good_frame(input int n, input int zero_pct);
        logic [7:0] enc[$];
        build_frame(n, zero_pct, enc);
        foreach (enc[i])
            send_item(enc[i], 16'(enc.size()));
    endtask

    task automatic send_broken_frame();
        logic [7:0]  enc[$];
        logic [15:0] len;
        int          lv;
        int          k;
        break_kind_t kind;
        build_frame(pick_payload_size(), $urandom_range(0, 40), enc);
        len = 16'(enc.size());
        kind = break_kind_t'($urandom_range(4));
        case (kind)
            BREAK_TERMINATOR: enc[enc.size()-1] = 8'($urandom_range(1, 255));
            BREAK_ZERO_BYTE:
            begin
                if (enc.size() > 1)
                    enc[$urandom_range(enc.size() - 2)] = 8'h00;
            end
            BREAK_RANDOM_BYTE: enc[$urandom_range(enc.size() - 1)] = 8'($urandom_range(255));
            BREAK_LENGTH:
            begin
                lv = int'(enc.size()) + int'($urandom_range(5)) - 2;
                len = (lv < 0) ? 16'h0000 : 16'(lv);
            end
            BREAK_TRUNCATE:
            begin
                // frame length shrinks mid-frame, closing it early
                if (enc.size() > 1)
                begin
                    k = $urandom_range(1, enc.size() - 1);
                    for (int i = 0; i < k; i++)
                        send_item(enc[i], len);
                    send_item(8'h00, 16'(k + 1));
                    return;
                end
            end
            default: ;
        endcase
        foreach (enc[i])
            send_item(enc[i], len);
    endtask

    task automatic send_noise();
        int n;
        logic [7:0] b;
        logic [15:0] len;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            b = ($urandom_range(99) < 30) ? 8'h00 : 8'($urandom_range(255));
            len = ($urandom_range(1)) ? 16'($urandom_range(8)) : 16'($urandom_range(16'hFFFF));
            send_item(b, len);
        end
    endtask

    // a length of one always closes the frame
    task automatic resync();
        if (sb.position != 16'h0000)
            send_item(8'($urandom_range(255)), 16'd1);
    endtask

    initial
    begin
        int base;
        int frame_no;
        int kind;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty and degenerate frames, each error kind
        send_item(8'h00, 16'd0);
        send_item(8'h00, 16'd1);
        send_item(8'hA5, 16'd1);
        send_packed(64'h0100, 2, 16'd2);
        send_packed(64'h03112200, 4, 16'd4);
        send_packed(64'h0000, 2, 16'd2);
        send_packed(64'h050100, 3, 16'd3);
        send_packed(64'h03000100, 4, 16'd4);
        write_capacity(16'd1);
        send_packed(64'h0211022200, 5, 16'd5);
        write_capacity(16'd0);
        send_packed(64'h028000, 3, 16'd3);
        write_capacity(16'hFFFF);

        base = items_sent;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 67;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 67;
                end
                default:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 15;
                end
            endcase
            if (p == 1)
                write_capacity(16'h0000);
            else if (p > 1)
                write_capacity(pick_capacity());
            pause_at = items_sent + $urandom_range(50, 300);
            // long nonzero run so that full-length blocks show up
            if (p == 0)
                send_good_frame($urandom_range(254, 260), 1);
            frame_no = 0;
            while (items_sent < base + (p + 1) * TARGET_ITEMS / 4)
            begin
                if (frame_no % 8 == 7)
                    write_capacity(pick_capacity());
                kind = $urandom_range(99);
                if (kind < 70)
                    send_good_frame(pick_payload_size(), $urandom_range(0, 40));
                else if (kind < 90)
                    send_broken_frame();
                else
                    send_noise();
                resync();
                frame_no++;
            end
        end
        write_capacity(16'hFFFF);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run: %0d bytes in, %0d results checked, %0d capacity writes, %0d cycles",
                 items_sent, sb.results_checked, cap_writes, cycles);
        $display("frames closed: ok %0d, source length %0d, invalid zero %0d, dest full %0d",
                 sb.status_count[ST_OK], sb.status_count[ST_SRC_LEN],
                 sb.status_count[ST_INVALID_ZERO], sb.status_count[ST_DEST_FULL]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cfd_pkg.sv
rtl/cfd_core.sv
rtl/cfd_out_fifo.sv
rtl/cobs_frame_decoder.sv
rtl/cfd_checker.sv
verif/tb.sv
